// ===== src/bpq_pkg.sv =====
// ---------------------------------------------------------------------------
// bpq_pkg
// Shared types, sizes and helpers for the bucket priority queue.
// ---------------------------------------------------------------------------
package bpq_pkg;

  localparam int NUM_WEIGHTS = 64;
  localparam int CAPACITY    = 256;
  localparam int WW          = $clog2(NUM_WEIGHTS);
  localparam int SW          = $clog2(CAPACITY);
  localparam int CW          = $clog2(CAPACITY + 1);
  localparam int DW          = 32;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_WEIGHT = 2'd1;
  localparam logic [1:0] ERR_FULL   = 2'd2;

  // Classified request handed from front to back
  typedef struct packed {
    kind_t                kind;
    logic                 over;
    logic [WW-1:0]        weight;
    logic signed [DW-1:0] value;
  } op_t;

  // Result of one request
  typedef struct packed {
    logic                 popped_valid;
    logic signed [DW-1:0] popped_value;
    logic [WW-1:0]        popped_weight;
    logic [1:0]           error;
    logic [CW-1:0]        entry_count;
    logic                 is_empty;
    logic [WW-1:0]        least_weight;
    logic signed [DW-1:0] top_value;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_PUSH_LINK,
    ST_POP_RD,
    ST_POP_WR,
    ST_POP_HEAD,
    ST_POP_VAL,
    ST_POP_TOP,
    ST_EMIT
  } state_t;

  // Lowest set bit of the non-empty map; zero when none is set
  function automatic logic [WW-1:0] find_first(input logic [NUM_WEIGHTS-1:0] map);
    logic [WW-1:0] idx;
    idx = '0;
    for (int i = NUM_WEIGHTS - 1; i >= 0; i--) begin
      if (map[i]) begin
        idx = WW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/bpq_if.sv =====
// ---------------------------------------------------------------------------
// bpq_req_if / bpq_resp_if
// Valid/ready channels carrying requests and results.
// ---------------------------------------------------------------------------
interface bpq_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        weight;
  logic signed [31:0] value;

  modport source (output valid, kind, weight, value, input ready);
  modport sink   (input valid, kind, weight, value, output ready);
endinterface

interface bpq_resp_if;
  logic               valid;
  logic               ready;
  logic               popped_valid;
  logic signed [31:0] popped_value;
  logic [5:0]         popped_weight;
  logic [1:0]         error;
  logic [8:0]         entry_count;
  logic               is_empty;
  logic [5:0]         least_weight;
  logic signed [31:0] top_value;

  modport source (output valid, popped_valid, popped_value, popped_weight, error,
                  entry_count, is_empty, least_weight, top_value, input ready);
  modport sink   (input valid, popped_valid, popped_value, popped_weight, error,
                  entry_count, is_empty, least_weight, top_value, output ready);
endinterface

// ===== src/bpq_front.sv =====
// ---------------------------------------------------------------------------
// bpq_front
// Accepts requests, checks the weight limit and queues them for the back.
// ---------------------------------------------------------------------------
module bpq_front
  import bpq_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [WW-1:0] weight_limit,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_kind,
  input  logic [7:0]    in_weight,
  input  logic [DW-1:0] in_value,
  output logic          op_valid,
  input  logic          op_ready,
  output op_t           op
);

  op_t        fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  op_t        cls;
  logic       push;
  logic       pop;

  // Classify the incoming request
  always_comb begin
    cls.kind   = kind_t'(in_kind);
    cls.over   = in_weight > {{(8-WW){1'b0}}, weight_limit};
    cls.weight = in_weight[WW-1:0];
    cls.value  = in_value;
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign op_valid = (fill != 2'd0);
  assign pop      = op_valid && op_ready;
  assign op       = fifo[rd_ptr];

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/bpq_back.sv =====
// ---------------------------------------------------------------------------
// bpq_back
// Carries out push, pop, clear and no-op requests on the bucket store and drives results.
// ---------------------------------------------------------------------------
module bpq_back
  import bpq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  op_t  op,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // Stores
  logic [DW-1:0] val_mem  [CAPACITY];
  logic [SW-1:0] link_mem [CAPACITY];
  logic [SW-1:0] head_mem [NUM_WEIGHTS];
  logic [SW-1:0] tail_mem [NUM_WEIGHTS];

  logic [DW-1:0] val_rd;
  logic [SW-1:0] link_rd;
  logic [SW-1:0] head_rd;
  logic [SW-1:0] tail_rd;

  // Memory controls
  logic          val_we, val_re, link_we, link_re, head_we, head_re, tail_we, tail_re;
  logic [SW-1:0] val_wa, val_ra, link_wa, link_ra;
  logic [WW-1:0] head_wa, head_ra, tail_wa, tail_ra;
  logic [DW-1:0] val_wd;
  logic [SW-1:0] link_wd, head_wd, tail_wd;

  state_t state, state_next;

  logic [NUM_WEIGHTS-1:0] bitmap;
  logic [SW-1:0]          free_head;
  logic [CW-1:0]          fresh;
  logic [CW-1:0]          count;
  logic [WW-1:0]          lowest;
  logic [SW-1:0]          top_slot;
  logic [DW-1:0]          top_value;
  op_t                    cur;
  logic [SW-1:0]          slot_r;
  logic                   pop_valid_r;
  logic [DW-1:0]          pop_value_r;
  logic [WW-1:0]          pop_weight_r;
  logic [1:0]             err_r;

  logic                   take;
  logic                   reuse;
  logic [SW-1:0]          new_slot;
  logic                   emptied;
  logic [NUM_WEIGHTS-1:0] bitmap_after;
  logic                   emit;

  assign op_ready = (state == ST_IDLE);
  assign take     = op_valid && op_ready;
  assign emit     = (state == ST_EMIT) && (!res_valid || res_ready);
  assign reuse    = fresh > count;
  assign new_slot = reuse ? free_head : fresh[SW-1:0];
  assign emptied  = (tail_rd == top_slot);
  always_comb begin
    bitmap_after = bitmap;
    bitmap_after[lowest] = 1'b0;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (op.kind)
            KIND_PUSH: begin
              if (op.over || count == CW'(CAPACITY)) begin
                state_next = ST_EMIT;
              end else begin
                state_next = ST_PUSH_RD;
              end
            end
            KIND_POP: begin
              state_next = (count == '0) ? ST_EMIT : ST_POP_RD;
            end
            default: state_next = ST_EMIT;
          endcase
        end
      end
      ST_PUSH_RD:   state_next = ST_PUSH_WR;
      ST_PUSH_WR:   state_next = ST_PUSH_LINK;
      ST_PUSH_LINK: state_next = ST_EMIT;
      ST_POP_RD:    state_next = ST_POP_WR;
      ST_POP_WR:    state_next = ST_POP_HEAD;
      ST_POP_HEAD:  state_next = ST_POP_VAL;
      ST_POP_VAL:   state_next = ST_POP_TOP;
      ST_POP_TOP:   state_next = ST_EMIT;
      ST_EMIT:      state_next = emit ? ST_IDLE : ST_EMIT;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Memory port controls per state
  always_comb begin
    val_we = 1'b0; val_re = 1'b0; link_we = 1'b0; link_re = 1'b0;
    head_we = 1'b0; head_re = 1'b0; tail_we = 1'b0; tail_re = 1'b0;
    val_wa = new_slot; val_ra = head_rd; val_wd = cur.value;
    link_wa = tail_rd; link_ra = free_head; link_wd = new_slot;
    head_wa = cur.weight; head_ra = lowest; head_wd = new_slot;
    tail_wa = cur.weight; tail_ra = cur.weight; tail_wd = new_slot;
    case (state)
      ST_PUSH_RD: begin
        link_re = 1'b1;
        tail_re = 1'b1;
      end
      ST_PUSH_WR: begin
        val_we  = 1'b1;
        tail_we = 1'b1;
        link_we = bitmap[cur.weight];
        head_we = !bitmap[cur.weight];
      end
      ST_PUSH_LINK: begin
        link_we = 1'b1;
        link_wa = slot_r;
        link_wd = '0;
      end
      ST_POP_RD: begin
        link_re = 1'b1;
        link_ra = top_slot;
        tail_re = 1'b1;
        tail_ra = lowest;
      end
      ST_POP_WR: begin
        link_we = 1'b1;
        link_wa = top_slot;
        link_wd = free_head;
        head_we = !emptied;
        head_wa = lowest;
        head_wd = link_rd;
      end
      ST_POP_HEAD: head_re = 1'b1;
      ST_POP_VAL:  val_re  = 1'b1;
      default: ;
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (val_re) begin
      val_rd <= val_mem[val_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_rd <= link_mem[link_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_rd <= head_mem[head_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    if (tail_re) begin
      tail_rd <= tail_mem[tail_ra];
    end
  end

  // Bookkeeping and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bitmap    <= '0;
      free_head <= '0;
      fresh     <= '0;
      count     <= '0;
      lowest    <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Raise the result when emitted, drop it once taken
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take && op.kind == KIND_CLEAR) begin
            bitmap    <= '0;
            free_head <= '0;
            fresh     <= '0;
            count     <= '0;
            lowest    <= '0;
          end
        end
        ST_PUSH_WR: begin
          if (reuse) begin
            free_head <= link_rd;
          end else begin
            fresh <= fresh + 1'b1;
          end
          bitmap[cur.weight] <= 1'b1;
          if (count == '0 || cur.weight < lowest) begin
            lowest <= cur.weight;
          end
          count <= count + 1'b1;
        end
        ST_POP_WR: begin
          free_head <= top_slot;
          count     <= count - 1'b1;
          if (emptied) begin
            bitmap[lowest] <= 1'b0;
            lowest         <= find_first(bitmap_after);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take) begin
          cur         <= op;
          pop_valid_r <= 1'b0;
          err_r       <= ERR_NONE;
          if (op.kind == KIND_PUSH) begin
            if (op.over) begin
              err_r <= ERR_WEIGHT;
            end else if (count == CW'(CAPACITY)) begin
              err_r <= ERR_FULL;
            end
          end
        end
      end
      ST_PUSH_WR: begin
        slot_r <= new_slot;
        if (count == '0 || cur.weight < lowest) begin
          top_slot  <= new_slot;
          top_value <= cur.value;
        end
      end
      ST_POP_WR: begin
        pop_valid_r  <= 1'b1;
        pop_value_r  <= top_value;
        pop_weight_r <= lowest;
      end
      ST_POP_VAL: top_slot  <= head_rd;
      ST_POP_TOP: top_value <= val_rd;
      ST_EMIT: begin
        if (emit) begin
          res.popped_valid  <= pop_valid_r;
          res.popped_value  <= pop_valid_r ? pop_value_r : '0;
          res.popped_weight <= pop_valid_r ? pop_weight_r : '0;
          res.error         <= err_r;
          res.entry_count   <= count;
          res.is_empty      <= (count == '0);
          res.least_weight  <= (count == '0) ? '0 : lowest;
          res.top_value     <= (count == '0) ? '0 : top_value;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/bucket_priority_queue.sv =====
// Steps: push runs the read, write and link states, pop the read, write, head,
// value and top states; clear, no-op and rejected push go straight to emit.
// The back works on one request at a time and waits in emit on an output stall.
// Its pop path (link read, head update, head and value re-read for the new top)
// is the longest. A two-entry request queue keeps accepting while the back works.
// Reset (rst, synchronous): queue empty, weight limit 63, no result pending.
// ---------------------------------------------------------------------------
// bucket_priority_queue
// Bucket priority queue: one FIFO per weight, chained in a shared store.
// ---------------------------------------------------------------------------
module bucket_priority_queue
  import bpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  bpq_req_if.sink    req,
  bpq_resp_if.source resp
);

  logic [WW-1:0] weight_limit;
  logic          op_valid;
  logic          op_ready;
  op_t           op;
  res_t          res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_limit <= WW'(NUM_WEIGHTS - 1);
    end else if (cfg_we) begin
      weight_limit <= cfg_wdata;
    end
  end

  bpq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .weight_limit (weight_limit),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .in_kind      (req.kind),
    .in_weight    (req.weight),
    .in_value     (req.value),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .op           (op)
  );

  bpq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (resp.valid),
    .res_ready (resp.ready),
    .res       (res)
  );

  // Drive the result channel
  assign resp.popped_valid  = res.popped_valid;
  assign resp.popped_value  = res.popped_value;
  assign resp.popped_weight = res.popped_weight;
  assign resp.error         = res.error;
  assign resp.entry_count   = res.entry_count;
  assign resp.is_empty      = res.is_empty;
  assign resp.least_weight  = res.least_weight;
  assign resp.top_value     = res.top_value;

`ifndef SYNTHESIS
  a_pop_no_error: assert property (@(posedge clk) disable iff (rst)
    resp.valid && resp.popped_valid |-> resp.error == ERR_NONE)
    else $error("pop result carries an error code");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    resp.valid |-> resp.entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    resp.valid && resp.is_empty |-> resp.least_weight == '0 && resp.top_value == '0
      && resp.entry_count == '0)
    else $error("empty queue reports a top entry");
  a_reset_idle: assert property (@(posedge clk) rst |=> !resp.valid)
    else $error("result pending after reset");
`endif

endmodule
